// ===== sv/dnp_pkg.sv =====
// Shared types, state codes and widths for the decimal number parser.
`timescale 1ns / 1ps
`default_nettype none

package dnp_pkg;

   // accumulator width, 8 to 64
   localparam int MANT_BITS = 32;
   // result mantissa width is fixed by the result beat
   localparam int OUT_BITS  = 32;
   // widening used for the result saturation check
   localparam int EXT_BITS  = (MANT_BITS > OUT_BITS) ? MANT_BITS : OUT_BITS + 1;
   localparam int FRAC_BITS = 5;

   localparam logic [MANT_BITS-1:0] ACC_MAX  = {MANT_BITS{1'b1}};
   localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

   // parser state codes
   localparam logic [2:0] ST_INITIAL  = 3'd0;
   localparam logic [2:0] ST_INTEGER  = 3'd1;
   localparam logic [2:0] ST_FRACTION = 3'd2;
   localparam logic [2:0] ST_DONE     = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;

   // character codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // result status codes
   localparam logic STATUS_NUMBER = 1'b0;
   localparam logic STATUS_ERROR  = 1'b1;

   // class of one received byte; none of the flags set means noise
   typedef struct packed {
      logic       is_digit;
      logic       is_comma;
      logic       is_newline;
      logic [3:0] digit;
   } cls_type;

   // result produced by one parser step
   typedef struct packed {
      logic                 emit;
      logic                 status;
      logic [OUT_BITS-1:0]  mantissa;
      logic [FRAC_BITS-1:0] fraction_digits;
      logic                 overflowed;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/dnp_if.sv =====
// Channel interfaces: received byte beats and parse result beats.
`timescale 1ns / 1ps
`default_nettype none

interface dnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_byte;

   modport source (output valid, output ascii_byte, input ready);
   modport sink   (input valid, input ascii_byte, output ready);
endinterface

interface dnp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [dnp_pkg::OUT_BITS-1:0]  mantissa;
   logic [dnp_pkg::FRAC_BITS-1:0] fraction_digits;
   logic                          overflowed;

   modport source (output valid, output status, output mantissa,
                   output fraction_digits, output overflowed, input ready);
   modport sink   (input valid, input status, input mantissa,
                   input fraction_digits, input overflowed, output ready);
endinterface

`default_nettype wire

// ===== sv/dnp_classify.sv =====
// Byte classifier: digit, comma, newline or noise.
`timescale 1ns / 1ps
`default_nettype none

module dnp_classify (
   input  wire logic [7:0]       ascii_byte,
   output dnp_pkg::cls_type      byte_class
);

   logic [7:0] offset;

   // subtract the code of zero to get the digit value
   assign offset = ascii_byte - dnp_pkg::CHAR_ZERO;

   always_comb begin
      byte_class.is_digit   = (ascii_byte >= dnp_pkg::CHAR_ZERO) &&
                              (ascii_byte <= dnp_pkg::CHAR_NINE);
      byte_class.is_comma   = (ascii_byte == dnp_pkg::CHAR_COMMA);
      byte_class.is_newline = (ascii_byte == dnp_pkg::CHAR_NEWLINE);
      byte_class.digit      = offset[3:0];
   end

endmodule

`default_nettype wire

// ===== sv/dnp_core.sv =====
// Parser state machine with mantissa accumulator and fraction counter.
`timescale 1ns / 1ps
`default_nettype none

module dnp_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  dnp_pkg::cls_type      byte_class,
   output dnp_pkg::result_type   result
);

   localparam int MB = dnp_pkg::MANT_BITS;
   localparam int FB = dnp_pkg::FRAC_BITS;

   logic [2:0]    st_ff,   st_in;
   logic [MB-1:0] acc_ff,  acc_in;
   logic [FB-1:0] frac_ff, frac_in;
   logic          of_ff,   of_in;

   logic [MB+3:0] acc_ext;
   logic [MB+3:0] prod;
   logic          push_sat;
   logic [MB-1:0] push_acc;
   logic          frac_sat;
   logic [FB-1:0] frac_inc;
   logic [dnp_pkg::EXT_BITS-1:0] mant_ext;
   logic          mant_sat;
   logic [dnp_pkg::OUT_BITS-1:0] mant_out;
   logic          noise;

   assign noise = !byte_class.is_digit && !byte_class.is_comma && !byte_class.is_newline;

   // times ten plus digit, saturate when the product leaves the accumulator
   assign acc_ext  = (MB+4)'(acc_ff);
   assign prod     = (acc_ext << 3) + (acc_ext << 1) + (MB+4)'(byte_class.digit);
   assign push_sat = |prod[MB+3:MB];
   assign push_acc = push_sat ? dnp_pkg::ACC_MAX : prod[MB-1:0];

   // fraction count saturates at its top code
   assign frac_sat = (frac_ff == dnp_pkg::FRAC_MAX);
   assign frac_inc = frac_sat ? dnp_pkg::FRAC_MAX : frac_ff + FB'(1);

   // clamp the accumulator to the result width
   assign mant_ext = dnp_pkg::EXT_BITS'(acc_ff);
   assign mant_sat = |mant_ext[dnp_pkg::EXT_BITS-1:dnp_pkg::OUT_BITS];
   assign mant_out = mant_sat ? {dnp_pkg::OUT_BITS{1'b1}}
                              : mant_ext[dnp_pkg::OUT_BITS-1:0];

   // next state and result for the current byte
   always_comb begin
      st_in   = st_ff;
      acc_in  = acc_ff;
      frac_in = frac_ff;
      of_in   = of_ff;
      result  = '0;
      case (st_ff)
         dnp_pkg::ST_INITIAL, dnp_pkg::ST_DONE: begin
            if (byte_class.is_digit) begin
               acc_in  = MB'(byte_class.digit);
               frac_in = '0;
               of_in   = 1'b0;
               st_in   = dnp_pkg::ST_INTEGER;
            end else if (byte_class.is_comma) begin
               acc_in  = '0;
               frac_in = '0;
               of_in   = 1'b0;
               st_in   = dnp_pkg::ST_FRACTION;
            end else if (byte_class.is_newline) begin
               st_in   = dnp_pkg::ST_DONE;
            end else begin
               st_in         = dnp_pkg::ST_ERROR;
               result.emit   = 1'b1;
               result.status = dnp_pkg::STATUS_ERROR;
            end
         end
         dnp_pkg::ST_INTEGER: begin
            if (byte_class.is_digit) begin
               acc_in = push_acc;
               of_in  = of_ff | push_sat;
            end else if (byte_class.is_comma) begin
               st_in = dnp_pkg::ST_FRACTION;
            end else if (byte_class.is_newline) begin
               st_in                  = dnp_pkg::ST_DONE;
               result.emit            = 1'b1;
               result.status          = dnp_pkg::STATUS_NUMBER;
               result.mantissa        = mant_out;
               result.fraction_digits = frac_ff;
               result.overflowed      = of_ff | mant_sat;
            end else begin
               st_in         = dnp_pkg::ST_ERROR;
               result.emit   = 1'b1;
               result.status = dnp_pkg::STATUS_ERROR;
            end
         end
         dnp_pkg::ST_FRACTION: begin
            if (byte_class.is_digit) begin
               acc_in  = push_acc;
               frac_in = frac_inc;
               of_in   = of_ff | push_sat | frac_sat;
            end else if (byte_class.is_newline) begin
               st_in                  = dnp_pkg::ST_DONE;
               result.emit            = 1'b1;
               result.status          = dnp_pkg::STATUS_NUMBER;
               result.mantissa        = mant_out;
               result.fraction_digits = frac_ff;
               result.overflowed      = of_ff | mant_sat;
            end else begin
               // a second comma counts as noise here
               st_in         = dnp_pkg::ST_ERROR;
               result.emit   = 1'b1;
               result.status = dnp_pkg::STATUS_ERROR;
            end
         end
         default: begin
            // error: drop everything up to the next newline
            st_in = byte_class.is_newline ? dnp_pkg::ST_DONE : dnp_pkg::ST_ERROR;
         end
      endcase
      if (noise && st_ff == dnp_pkg::ST_ERROR) begin
         st_in = dnp_pkg::ST_ERROR;
      end
   end

   // advance the parser state once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= dnp_pkg::ST_INITIAL;
         acc_ff  <= '0;
         frac_ff <= '0;
         of_ff   <= 1'b0;
      end else if (step_en) begin
         st_ff   <= st_in;
         acc_ff  <= acc_in;
         frac_ff <= frac_in;
         of_ff   <= of_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/decimal_number_parser.sv =====
// Top level of the decimal number parser: input register, parser step, result register.
//
//   channel | dir | payload                                         | beat
//   req     | in  | ascii_byte[7:0]                                 | one character
//   rsp     | out | status, mantissa[31:0], fraction_digits[4:0],   | one number or error
//           |     | overflowed                                      |
//
// A byte is held in the input register and then takes one parser step, whose result is
// loaded into the result register; one byte per cycle is sustained while the result register
// is empty or its beat is taken, as the times-ten update of the accumulator is combinational.
// Reset is synchronous and returns the parser to its initial state with both
// registers empty. A stalled result holds in the result register; the input register
// holds its byte until the result register frees, and req.ready drops while both are full.
`timescale 1ns / 1ps
`default_nettype none

module decimal_number_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   dnp_req_if.sink    req,
   dnp_rsp_if.source  rsp
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   logic                          rsp_status_ff;
   logic [dnp_pkg::OUT_BITS-1:0]  rsp_mant_ff;
   logic [dnp_pkg::FRAC_BITS-1:0] rsp_frac_ff;
   logic                          rsp_of_ff;

   logic                out_free;
   logic                advance;
   dnp_pkg::cls_type    byte_class;
   dnp_pkg::result_type result;

   // pipeline flow control
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign advance   = in_vld_ff && out_free;
   assign req.ready = !in_vld_ff || out_free;

   // capture a new byte whenever the input register frees
   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req.ready) begin
         in_vld_in  = req.valid;
         in_byte_in = req.ascii_byte;
      end
   end

   dnp_classify u_classify (
      .ascii_byte (in_byte_ff),
      .byte_class (byte_class)
   );

   dnp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .byte_class (byte_class),
      .result     (result)
   );

   // load a result on a step, clear it once taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = result.emit;
      end else if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance && result.emit) begin
         rsp_status_ff <= result.status;
         rsp_mant_ff   <= result.mantissa;
         rsp_frac_ff   <= result.fraction_digits;
         rsp_of_ff     <= result.overflowed;
      end
   end

   assign rsp.valid           = rsp_vld_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.mantissa        = rsp_mant_ff;
   assign rsp.fraction_digits = rsp_frac_ff;
   assign rsp.overflowed      = rsp_of_ff;

   // an error beat carries no number
   a_error_beat_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_status_ff == dnp_pkg::STATUS_ERROR) |->
         (rsp_mant_ff == '0) && (rsp_frac_ff == '0) && !rsp_of_ff)
      else $error("error beat with nonzero number fields");

   // a byte blocked by a full result register stays in place
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_free |=> in_vld_ff && $stable(in_byte_ff))
      else $error("input byte lost while result stalled");

   // a result only appears after a parser step
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(advance))
      else $error("result beat without a parser step");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && !in_vld_ff)
      else $error("registers not empty after reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the decimal number parser: byte stream in, parse results out.
`timescale 1ns / 1ps

module tb_top;

   localparam int ITEM_COUNT  = 1850;
   localparam int PAUSE_POINT = 900;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_TAIL  = 8;

   // Tracks the parser state and holds the results it owes, oldest first
   class number_checker;
      logic [2:0]                    pstate;
      logic [dnp_pkg::MANT_BITS-1:0] acc;
      logic [dnp_pkg::FRAC_BITS-1:0] frac;
      logic                          ovf;
      dnp_pkg::result_type           due_numbers[$];
      int                            errors;

      function new();
         pstate = dnp_pkg::ST_INITIAL;
         acc    = '0;
         frac   = '0;
         ovf    = 1'b0;
         errors = 0;
      endfunction

      // times ten plus digit, saturating at the accumulator's full scale
      function void add_digit(input logic [3:0] d);
         bit [63:0] top;
         top = 64'(dnp_pkg::ACC_MAX);
         if (64'(acc) > (top - 64'(d)) / 10) begin
            acc = dnp_pkg::ACC_MAX;
            ovf = 1'b1;
         end else begin
            acc = dnp_pkg::MANT_BITS'(64'(acc) * 10 + 64'(d));
         end
      endfunction

      function void owe_number();
         dnp_pkg::result_type r;
         bit [63:0]           m;
         m = 64'(acc);
         r = '0;
         r.emit            = 1'b1;
         r.status          = dnp_pkg::STATUS_NUMBER;
         r.fraction_digits = frac;
         if (m > ((64'd1 << dnp_pkg::OUT_BITS) - 1)) begin
            r.mantissa   = '1;
            r.overflowed = 1'b1;
         end else begin
            r.mantissa   = m[dnp_pkg::OUT_BITS-1:0];
            r.overflowed = ovf;
         end
         due_numbers.push_back(r);
      endfunction

      function void owe_error();
         dnp_pkg::result_type r;
         r        = '0;
         r.emit   = 1'b1;
         r.status = dnp_pkg::STATUS_ERROR;
         due_numbers.push_back(r);
         pstate = dnp_pkg::ST_ERROR;
      endfunction

      // advance on one accepted byte
      function void take_char(input logic [7:0] b);
         bit         is_digit;
         bit         is_comma;
         bit         is_nl;
         logic [2:0] st;
         is_digit = (b >= dnp_pkg::CHAR_ZERO) && (b <= dnp_pkg::CHAR_NINE);
         is_comma = (b == dnp_pkg::CHAR_COMMA);
         is_nl    = (b == dnp_pkg::CHAR_NEWLINE);
         st       = (pstate > dnp_pkg::ST_ERROR) ? dnp_pkg::ST_ERROR : pstate;
         case (st)
            dnp_pkg::ST_INITIAL, dnp_pkg::ST_DONE: begin
               if (is_digit) begin
                  acc    = dnp_pkg::MANT_BITS'(b[3:0]);
                  frac   = '0;
                  ovf    = 1'b0;
                  pstate = dnp_pkg::ST_INTEGER;
               end else if (is_comma) begin
                  acc    = '0;
                  frac   = '0;
                  ovf    = 1'b0;
                  pstate = dnp_pkg::ST_FRACTION;
               end else if (is_nl) begin
                  pstate = dnp_pkg::ST_DONE;
               end else begin
                  owe_error();
               end
            end
            dnp_pkg::ST_INTEGER: begin
               if (is_digit) begin
                  add_digit(b[3:0]);
               end else if (is_comma) begin
                  pstate = dnp_pkg::ST_FRACTION;
               end else if (is_nl) begin
                  pstate = dnp_pkg::ST_DONE;
                  owe_number();
               end else begin
                  owe_error();
               end
            end
            dnp_pkg::ST_FRACTION: begin
               if (is_digit) begin
                  add_digit(b[3:0]);
                  if (frac == dnp_pkg::FRAC_MAX) begin
                     ovf = 1'b1;
                  end else begin
                     frac = frac + dnp_pkg::FRAC_BITS'(1);
                  end
               end else if (is_nl) begin
                  pstate = dnp_pkg::ST_DONE;
                  owe_number();
               end else begin
                  // noise or a second comma
                  owe_error();
               end
            end
            default: begin
               pstate = is_nl ? dnp_pkg::ST_DONE : dnp_pkg::ST_ERROR;
            end
         endcase
      endfunction

      // compare one result beat with the oldest owed result
      function void match_result(input logic                          status,
                                 input logic [dnp_pkg::OUT_BITS-1:0]  mantissa,
                                 input logic [dnp_pkg::FRAC_BITS-1:0] fraction_digits,
                                 input logic                          overflowed);
         dnp_pkg::result_type e;
         if (due_numbers.size() == 0) begin
            $error("result beat arrived with nothing owed");
            errors++;
            return;
         end
         e = due_numbers.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
         if (mantissa !== e.mantissa) begin
            $error("mantissa: expected %0d, got %0d", e.mantissa, mantissa);
            errors++;
         end
         if (fraction_digits !== e.fraction_digits) begin
            $error("fraction_digits: expected %0d, got %0d",
                   e.fraction_digits, fraction_digits);
            errors++;
         end
         if (overflowed !== e.overflowed) begin
            $error("overflowed: expected %0d, got %0d", e.overflowed, overflowed);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   dnp_req_if req_chan ();
   dnp_rsp_if rsp_chan ();

   decimal_number_parser uut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   number_checker checker_h;
   int            chars_taken;
   int            idle_cycles;
   int            ready_hold;
   bit            calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // random gap before a byte: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((b >= dnp_pkg::CHAR_ZERO && b <= dnp_pkg::CHAR_NINE) ||
                 b == dnp_pkg::CHAR_COMMA || b == dnp_pkg::CHAR_NEWLINE);
      return b;
   endfunction

   function automatic logic [7:0] digit_char();
      return dnp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // present one byte and hold it until the parser takes it
   task automatic send_char(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.ascii_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      checker_h.take_char(b);
      chars_taken++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_digits(input int n);
      for (int i = 0; i < n; i++) send_char(digit_char());
   endtask

   // well-formed number line, sometimes long enough to saturate
   task automatic send_number();
      int n_int;
      int n_frac;
      bit has_comma;
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1) == 1) begin
            send_text("42949672");
            n_int = $urandom_range(1, 4);
         end else begin
            n_int = $urandom_range(9, 14);
         end
      end else begin
         n_int = $urandom_range(0, 6);
      end
      has_comma = ($urandom_range(0, 9) < 6);
      if (n_int == 0 && !has_comma) n_int = 1;
      send_digits(n_int);
      if (has_comma) begin
         send_char(dnp_pkg::CHAR_COMMA);
         n_frac = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 36)
                                               : $urandom_range(0, 6);
         send_digits(n_frac);
      end
      send_char(dnp_pkg::CHAR_NEWLINE);
   endtask

   // number broken by noise or a second comma, then bytes to be dropped
   task automatic send_broken();
      send_digits($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 1) begin
         send_char(dnp_pkg::CHAR_COMMA);
         send_digits($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 1) send_char(dnp_pkg::CHAR_COMMA);
         else send_char(noise_char());
      end else begin
         send_char(noise_char());
      end
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(0, 2) == 0) send_char(dnp_pkg::CHAR_COMMA);
         else if ($urandom_range(0, 1) == 1) send_char(digit_char());
         else send_char(noise_char());
      end
      send_char(dnp_pkg::CHAR_NEWLINE);
   endtask

   task automatic send_junk();
      repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
      send_char(dnp_pkg::CHAR_NEWLINE);
   endtask

   task automatic wait_for_results();
      while (checker_h.due_numbers.size() != 0) @(posedge clock);
   endtask

   // main stimulus
   initial begin
      bit paused;
      int kind;
      checker_h           = new();
      chars_taken         = 0;
      calm                = 1'b0;
      paused              = 1'b0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.ascii_byte <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: simple number, comma forms, empty line, noise, second comma
      send_text("0\n12,5\n,7\n,\n\n9x7\n1,2,3\n");
      send_char(8'hFF);
      send_char(dnp_pkg::CHAR_NEWLINE);

      // random lines until enough bytes have been taken
      while (chars_taken < ITEM_COUNT) begin
         calm = ($urandom_range(0, 7) == 0);
         if (!paused && chars_taken >= PAUSE_POINT) begin
            // hold off until the parser has delivered everything owed
            req_chan.valid <= 1'b0;
            @(posedge clock);
            wait_for_results();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 60) send_number();
         else if (kind < 70) send_char(dnp_pkg::CHAR_NEWLINE);
         else if (kind < 85) send_broken();
         else send_junk();
      end
      req_chan.valid <= 1'b0;
      calm = 1'b0;

      // drain and let the pipeline settle
      wait_for_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (checker_h.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // result side back-pressure: runs of ready, short stalls, a few long ones
   always @(posedge clock) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (reset || calm) begin
         rsp_chan.ready <= 1'b1;
         ready_hold     <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (roll < 60) begin
         rsp_chan.ready <= 1'b1;
         ready_hold     <= $urandom_range(0, 12);
      end else if (roll < 92) begin
         rsp_chan.ready <= 1'b0;
         ready_hold     <= $urandom_range(0, 2);
      end else begin
         rsp_chan.ready <= 1'b0;
         ready_hold     <= $urandom_range(8, 40);
      end
   end

   // check each result beat
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         checker_h.match_result(rsp_chan.status, rsp_chan.mantissa,
                                rsp_chan.fraction_digits, rsp_chan.overflowed);
      end
   end

   // stop the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
